>>> design/pdr_pkg.sv
package pdr_pkg;

	// Field widths
	localparam int MEAS_W    = 10;
	localparam int DT_W      = 16;
	localparam int GAIN_W    = 16;
	localparam int ERR_W     = MEAS_W + 1;
	localparam int LAST_W    = 12;
	localparam int INTEG_W   = 40;
	localparam int FRAC_W    = 8;
	localparam int MS_PER_S  = 1000;
	localparam int CFG_IDX_W = 3;

	// Shared serial multiplier: multiplicand and multiplier widths
	localparam int MUL_A_W = INTEG_W;
	localparam int MUL_B_W = DT_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Shared serial divider: divisor width holds 256 * elapsed_ms and 256 * 1000
	localparam int DIV_D_W = DT_W + FRAC_W;
	localparam logic [DIV_D_W-1:0] I_DIVISOR = DIV_D_W'((1 << FRAC_W) * MS_PER_S);

	// Scaled error step (delta error times 1000) and PID sum widths
	localparam int D1000_W = 22;
	localparam int SUM_W   = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE   = 3'd0,
		REG_TARGET   = 3'd1,
		REG_BAND     = 3'd2,
		REG_GAIN_P   = 3'd3,
		REG_GAIN_I   = 3'd4,
		REG_GAIN_D   = 3'd5,
		REG_DUTY_MIN = 3'd6,
		REG_DUTY_MAX = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M_IOLD,
		S_D_IOLD,
		S_M_EDT,
		S_M_INEW,
		S_D_INEW,
		S_M_P,
		S_M_D,
		S_D_D,
		S_SUM,
		S_CLAMP,
		S_DONE
	} ctl_state_t;

endpackage

>>> design/pdr_if.sv
interface pdr_in_if;
	logic                        valid;
	logic                        ready;
	logic [pdr_pkg::MEAS_W-1:0]  measured_humidity;
	logic [pdr_pkg::DT_W-1:0]    elapsed_ms;

	modport source (output valid, measured_humidity, elapsed_ms, input ready);
	modport sink (input valid, measured_humidity, elapsed_ms, output ready);
endinterface

interface pdr_out_if #(parameter int DUTY_BITS = 11);
	logic                        valid;
	logic                        ready;
	logic signed [DUTY_BITS-1:0] drive_duty;
	logic                        relay_on;

	modport source (output valid, drive_duty, relay_on, input ready);
	modport sink (input valid, drive_duty, relay_on, output ready);
endinterface

>>> design/pdr_smul.sv
module pdr_smul #(
	parameter int A_W = 40,
	parameter int B_W = 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic                     done,
	output logic signed [A_W+B_W-1:0] prod
);

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]   a_mag;
	logic [B_W-1:0]   b_mag;
	logic [A_W-1:0]   mcand_q;
	logic [P_W-1:0]   acc_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [A_W-1:0]   addend;
	logic [A_W:0]     top_sum;

	// Split operands into sign and magnitude
	assign a_mag = a[A_W-1] ? A_W'(~a + 1'b1) : A_W'(a);
	assign b_mag = b[B_W-1] ? B_W'(~b + 1'b1) : B_W'(b);

	// One multiplier bit per cycle: add to the upper half, shift right
	assign addend  = acc_q[0] ? mcand_q : '0;
	assign top_sum = {1'b0, acc_q[P_W-1:B_W]} + {1'b0, addend};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(B_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= a_mag;
			acc_q   <= {{A_W{1'b0}}, b_mag};
			neg_q   <= a[A_W-1] ^ b[B_W-1];
		end else if (cnt_q != '0) begin
			acc_q <= {top_sum, acc_q[B_W-1:1]};
		end
	end

	// Restore the sign of the product
	assign prod = neg_q ? $signed(P_W'(~acc_q + 1'b1)) : $signed(acc_q);
	assign done = done_q;

endmodule

>>> design/pdr_sdiv.sv
module pdr_sdiv #(
	parameter int N_W = 57,
	parameter int D_W = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [N_W-1:0] num,
	input  logic [D_W-1:0]        den,
	output logic                  done,
	output logic signed [N_W-1:0] quo
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   n_mag;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [D_W:0]     rem_sh;
	logic [D_W:0]     trial;
	logic             fits;

	assign n_mag = num[N_W-1] ? N_W'(~num + 1'b1) : N_W'(num);

	// One quotient bit per cycle, restoring
	assign rem_sh = {rem_q, quo_q[N_W-1]};
	assign trial  = rem_sh - {1'b0, den_q};
	assign fits   = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(N_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= n_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[N_W-1];
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? trial[D_W-1:0] : rem_sh[D_W-1:0];
		end
	end

	// Round toward minus infinity: a negative inexact quotient drops by one
	always_comb begin
		if (!neg_q) begin
			quo = $signed(quo_q);
		end else if (rem_q != '0) begin
			quo = $signed(~quo_q);
		end else begin
			quo = $signed(N_W'(~quo_q + 1'b1));
		end
	end

	assign done = done_q;

endmodule

>>> design/pid_duty_with_relay_hysteresis.sv
// When enabled, an accepted request makes five passes of the bit-serial multiplier and
// three passes of the bit-serial divider, then goes through the sum, clamp and load
// states; when disabled it goes straight to the load state. One request in flight at a
// time: a new request is taken only once the last result has been loaded into the
// output register, and the load waits while the output stalls.
// Reset clears the controller state, loads the register defaults and empties the output.
module pid_duty_with_relay_hysteresis #(
	parameter int DUTY_BITS = 11
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [pdr_pkg::CFG_IDX_W-1:0]              cfg_idx,
	input  logic [((DUTY_BITS > pdr_pkg::GAIN_W) ? DUTY_BITS : pdr_pkg::GAIN_W)-1:0] cfg_wdata,
	pdr_in_if.sink                                     sample,
	pdr_out_if.source                                  result
);

	localparam int MEAS_W  = pdr_pkg::MEAS_W;
	localparam int DT_W    = pdr_pkg::DT_W;
	localparam int GAIN_W  = pdr_pkg::GAIN_W;
	localparam int ERR_W   = pdr_pkg::ERR_W;
	localparam int LAST_W  = pdr_pkg::LAST_W;
	localparam int INTEG_W = pdr_pkg::INTEG_W;
	localparam int MUL_A_W = pdr_pkg::MUL_A_W;
	localparam int MUL_B_W = pdr_pkg::MUL_B_W;
	localparam int PROD_W  = pdr_pkg::PROD_W;
	localparam int DIV_D_W = pdr_pkg::DIV_D_W;
	localparam int D1000_W = pdr_pkg::D1000_W;
	localparam int SUM_W   = pdr_pkg::SUM_W;

	// Configuration registers
	logic                        enable_q;
	logic [MEAS_W-1:0]           target_q;
	logic [MEAS_W-1:0]           band_q;
	logic signed [GAIN_W-1:0]    gain_p_q;
	logic signed [GAIN_W-1:0]    gain_i_q;
	logic signed [GAIN_W-1:0]    gain_d_q;
	logic signed [DUTY_BITS-1:0] duty_min_q;
	logic signed [DUTY_BITS-1:0] duty_max_q;

	// Controller state
	logic                        relay_q;
	logic signed [INTEG_W-1:0]   integ_q;
	logic signed [LAST_W-1:0]    last_err_q;

	// Per-request working registers
	pdr_pkg::ctl_state_t         state_q, state_d;
	logic [DT_W-1:0]             dt_q;
	logic signed [ERR_W-1:0]     e_q;
	logic                        upd_q;
	logic signed [SUM_W-1:0]     i_new_q;
	logic signed [SUM_W-1:0]     p_q;
	logic signed [SUM_W-1:0]     d_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic signed [DUTY_BITS-1:0] res_duty_q;
	logic                        res_relay_q;

	// Output register
	logic                        out_full_q;
	logic signed [DUTY_BITS-1:0] out_duty_q;
	logic                        out_relay_q;

	// Unit handshakes and operands
	logic                        mul_start_q, mul_start_d;
	logic                        div_start_q, div_start_d;
	logic                        mul_done, div_done;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]    mul_prod;
	logic [DIV_D_W-1:0]          div_den;
	logic signed [PROD_W-1:0]    div_quo;

	// Combinational helpers
	logic                        accept;
	logic                        out_load;
	logic signed [ERR_W-1:0]     e_d;
	logic [MEAS_W:0]             hi_thr;
	logic signed [MEAS_W+1:0]    lo_thr;
	logic                        above, below;
	logic                        relay_d;
	logic [DT_W-1:0]             dt_d;
	logic signed [LAST_W-1:0]    err_step;
	logic signed [D1000_W-1:0]   step_w;
	logic signed [D1000_W-1:0]   step_k;
	logic signed [INTEG_W:0]     integ_sum;
	logic signed [INTEG_W-1:0]   integ_sat;
	logic signed [SUM_W-1:0]     lim_lo, lim_hi, clamp_lo, clamp_hi;
	logic                        upd_d;

	assign accept   = sample.valid && sample.ready;
	assign out_load = (state_q == pdr_pkg::S_DONE) && (!out_full_q || result.ready);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			target_q   <= MEAS_W'(500);
			band_q     <= MEAS_W'(20);
			gain_p_q   <= GAIN_W'(256);
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			duty_min_q <= '0;
			duty_max_q <= DUTY_BITS'(1023);
		end else if (cfg_we) begin
			unique case (pdr_pkg::cfg_reg_t'(cfg_idx))
				pdr_pkg::REG_ENABLE:   enable_q   <= cfg_wdata[0];
				pdr_pkg::REG_TARGET:   target_q   <= cfg_wdata[MEAS_W-1:0];
				pdr_pkg::REG_BAND:     band_q     <= cfg_wdata[MEAS_W-1:0];
				pdr_pkg::REG_GAIN_P:   gain_p_q   <= $signed(cfg_wdata[GAIN_W-1:0]);
				pdr_pkg::REG_GAIN_I:   gain_i_q   <= $signed(cfg_wdata[GAIN_W-1:0]);
				pdr_pkg::REG_GAIN_D:   gain_d_q   <= $signed(cfg_wdata[GAIN_W-1:0]);
				pdr_pkg::REG_DUTY_MIN: duty_min_q <= $signed(cfg_wdata[DUTY_BITS-1:0]);
				pdr_pkg::REG_DUTY_MAX: duty_max_q <= $signed(cfg_wdata[DUTY_BITS-1:0]);
				default: ;
			endcase
		end
	end

	// Error, relay thresholds and elapsed time of the incoming request
	assign e_d    = $signed({1'b0, sample.measured_humidity}) - $signed({1'b0, target_q});
	assign hi_thr = {1'b0, target_q} + {1'b0, band_q};
	assign lo_thr = $signed({2'b00, target_q}) - $signed({2'b00, band_q});
	assign above  = {1'b0, sample.measured_humidity} > hi_thr;
	assign below  = $signed({2'b00, sample.measured_humidity}) < lo_thr;
	assign dt_d   = (sample.elapsed_ms == '0) ? DT_W'(1) : sample.elapsed_ms;

	always_comb begin
		relay_d = relay_q;
		if (relay_q && above) begin
			relay_d = 1'b0;
		end else if (!relay_q && below) begin
			relay_d = 1'b1;
		end
	end

	// Error step times 1000 as shifts: 1000 = 1024 - 16 - 8
	assign err_step = $signed({e_q[ERR_W-1], e_q}) - last_err_q;
	assign step_w   = D1000_W'(err_step);
	assign step_k   = (step_w <<< 10) - (step_w <<< 4) - (step_w <<< 3);

	// Select multiplier operands for the current pass
	always_comb begin
		unique case (state_q)
			pdr_pkg::S_M_EDT: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = $signed({1'b0, dt_q});
			end
			pdr_pkg::S_M_P: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = MUL_B_W'(gain_p_q);
			end
			pdr_pkg::S_M_D: begin
				mul_a = MUL_A_W'(step_k);
				mul_b = MUL_B_W'(gain_d_q);
			end
			default: begin
				mul_a = MUL_A_W'(integ_q);
				mul_b = MUL_B_W'(gain_i_q);
			end
		endcase
	end

	assign div_den = (state_q == pdr_pkg::S_D_D) ? {dt_q, {pdr_pkg::FRAC_W{1'b0}}}
	                                             : pdr_pkg::I_DIVISOR;

	pdr_smul #(
		.A_W (MUL_A_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pdr_sdiv #(
		.N_W (PROD_W),
		.D_W (DIV_D_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (mul_prod),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Anti-windup check against the integral term before the update
	assign upd_d = e_q[ERR_W-1] ? (div_quo >= PROD_W'(duty_min_q))
	                            : (div_quo <= PROD_W'(duty_max_q));

	// Integral update with saturation at the 40-bit limits
	assign integ_sum = (INTEG_W + 1)'(integ_q) + (INTEG_W + 1)'(mul_prod);
	always_comb begin
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                               : {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_sat = integ_sum[INTEG_W-1:0];
		end
	end

	// Clamp: raise to the lower limit first, then lower to the upper limit
	assign lim_lo   = SUM_W'(duty_min_q);
	assign lim_hi   = SUM_W'(duty_max_q);
	assign clamp_lo = (sum_q < lim_lo) ? lim_lo : sum_q;
	assign clamp_hi = (clamp_lo > lim_hi) ? lim_hi : clamp_lo;

	// Sequence the passes over the shared units
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdr_pkg::S_IDLE:   if (sample.valid) state_d = enable_q ? pdr_pkg::S_M_IOLD
			                                                         : pdr_pkg::S_DONE;
			pdr_pkg::S_M_IOLD: if (mul_done) state_d = pdr_pkg::S_D_IOLD;
			pdr_pkg::S_D_IOLD: if (div_done) state_d = pdr_pkg::S_M_EDT;
			pdr_pkg::S_M_EDT:  if (mul_done) state_d = pdr_pkg::S_M_INEW;
			pdr_pkg::S_M_INEW: if (mul_done) state_d = pdr_pkg::S_D_INEW;
			pdr_pkg::S_D_INEW: if (div_done) state_d = pdr_pkg::S_M_P;
			pdr_pkg::S_M_P:    if (mul_done) state_d = pdr_pkg::S_M_D;
			pdr_pkg::S_M_D:    if (mul_done) state_d = pdr_pkg::S_D_D;
			pdr_pkg::S_D_D:    if (div_done) state_d = pdr_pkg::S_SUM;
			pdr_pkg::S_SUM:    state_d = pdr_pkg::S_CLAMP;
			pdr_pkg::S_CLAMP:  state_d = pdr_pkg::S_DONE;
			pdr_pkg::S_DONE:   if (out_load) state_d = pdr_pkg::S_IDLE;
			default:           state_d = pdr_pkg::S_IDLE;
		endcase

		mul_start_d = (state_d != state_q) && (state_d == pdr_pkg::S_M_IOLD ||
			state_d == pdr_pkg::S_M_EDT || state_d == pdr_pkg::S_M_INEW ||
			state_d == pdr_pkg::S_M_P || state_d == pdr_pkg::S_M_D);
		div_start_d = (state_d != state_q) && (state_d == pdr_pkg::S_D_IOLD ||
			state_d == pdr_pkg::S_D_INEW || state_d == pdr_pkg::S_D_D);
	end

	assign sample.ready = (state_q == pdr_pkg::S_IDLE);

	// Hold control state, controller state and the output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdr_pkg::S_IDLE;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_full_q  <= 1'b0;
			relay_q     <= 1'b0;
			integ_q     <= '0;
			last_err_q  <= '0;
		end else begin
			state_q     <= state_d;
			mul_start_q <= mul_start_d;
			div_start_q <= div_start_d;
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (result.ready) begin
				out_full_q <= 1'b0;
			end
			if (accept && enable_q) begin
				relay_q <= relay_d;
			end
			if (state_q == pdr_pkg::S_M_EDT && mul_done && upd_q) begin
				integ_q <= integ_sat;
			end
			if (state_q == pdr_pkg::S_CLAMP) begin
				last_err_q <= LAST_W'(e_q);
			end
		end
	end

	// Capture the request and the partial terms
	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q        <= dt_d;
			e_q         <= e_d;
			res_duty_q  <= '0;
			res_relay_q <= relay_q;
		end
		if (state_q == pdr_pkg::S_D_IOLD && div_done) begin
			upd_q <= upd_d;
		end
		if (state_q == pdr_pkg::S_D_INEW && div_done) begin
			i_new_q <= SUM_W'(div_quo);
		end
		if (state_q == pdr_pkg::S_M_P && mul_done) begin
			p_q <= SUM_W'(mul_prod >>> pdr_pkg::FRAC_W);
		end
		if (state_q == pdr_pkg::S_D_D && div_done) begin
			d_q <= SUM_W'(div_quo);
		end
		if (state_q == pdr_pkg::S_SUM) begin
			sum_q <= p_q + i_new_q + d_q;
		end
		if (state_q == pdr_pkg::S_CLAMP) begin
			res_duty_q  <= DUTY_BITS'(clamp_hi);
			res_relay_q <= relay_q;
		end
		if (out_load) begin
			out_duty_q  <= res_duty_q;
			out_relay_q <= res_relay_q;
		end
	end

	assign result.valid      = out_full_q;
	assign result.drive_duty = out_duty_q;
	assign result.relay_on   = out_relay_q;

endmodule

>>> design/pdr_checker.sv
module pdr_checker #(
	parameter int DUTY_BITS = 11
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        sample_valid,
	input logic                        sample_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic signed [DUTY_BITS-1:0] result_duty,
	input logic                        result_relay
);

	logic [1:0] outst_q;

	// Track requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			unique case ({sample_valid && sample_ready, result_valid && result_ready})
				2'b10:   outst_q <= outst_q + 1'b1;
				2'b01:   outst_q <= outst_q - 1'b1;
				default: outst_q <= outst_q;
			endcase
		end
	end

	// Drop ready after each request: one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("request accepted while another is in flight");

	// Deliver no result without a pending request
	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> outst_q != 2'd0)
		else $error("result without a pending request");

	// Refuse a request while one is being worked and one waits at the output
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q == 2'd2 |-> !sample_ready)
		else $error("ready with two requests pending");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_duty)
			&& $stable(result_relay))
		else $error("stalled result changed");

	// Empty the output during reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind pid_duty_with_relay_hysteresis pdr_checker #(.DUTY_BITS(DUTY_BITS)) u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_duty  (result.drive_duty),
	.result_relay (result.relay_on)
);
